### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define CGL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define CGL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cgl_pkg.sv
`timescale 1ns / 1ps

package cgl_pkg;

    localparam int X_W       = 25;   // argument width, Q1.24
    localparam int FRAC_W    = 24;   // fraction bits of the argument and result
    localparam int RES_W     = 26;   // result width, signed Q2.24
    localparam int TERM_W    = 50;   // recurrence terms, signed Q.48
    localparam int MAX_TERMS = 13;
    localparam int NUM_TERMS_DEF = 13;

    // Partial product widths for |b| * y, |b| split at the fraction point
    localparam int MH_W = TERM_W - FRAC_W;   // upper part of |b|
    localparam int PH_W = MH_W + X_W;        // upper partial product
    localparam int PL_W = FRAC_W + X_W;      // lower partial product before the shift

    // Series coefficients, round(c * 2^48); the tail terms vanish at this precision
    localparam logic signed [TERM_W-1:0] COEF_TAB [MAX_TERMS] = '{
        50'sd64335796780601,
        50'sd62414379084075,
        -50'sd1869401394326,
        50'sd50817045501,
        -50'sd1175542676,
        50'sd23305738,
        -50'sd402082,
        50'sd6125,
        -50'sd83,
        50'sd1,
        50'sd0,
        50'sd0,
        50'sd0
    };

    typedef struct packed {
        logic [X_W-1:0]           x;
        logic                     oor;
        logic signed [TERM_W-1:0] a;
        logic signed [TERM_W-1:0] b;
    } t_term;

    typedef struct packed {
        logic mul;   // advance the product register
        logic add;   // advance the sum register
    } t_step_en;

endpackage

### rtl/cgl_if.sv
`timescale 1ns / 1ps

interface cgl_in_if;
    import cgl_pkg::*;
    logic           valid;
    logic           ready;
    logic [X_W-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

interface cgl_out_if;
    import cgl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] func_value;
    logic                    out_of_range;

    modport source (output valid, output func_value, output out_of_range, input ready);
    modport sink   (input valid, input func_value, input out_of_range, output ready);
endinterface

### rtl/chebyshev_gamma_log_eval.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                              Handshake
// i_arg     in   x_value[24:0]  Q1.24 unsigned        valid/ready
// o_res     out  func_value[25:0] Q2.24 signed,       valid/ready
//                out_of_range
//
// One transaction enters per cycle while o_res is not stalled; there are
// two stages for each multiply-add of the recurrence plus the rounding stage.
// Reset (synchronous, active low) clears only the stage valid bits.
// Each stage advances when empty or when the stage after it advances, so a
// stall at o_res fills bubbles first and drops or repeats nothing.
`include "assert_macros.svh"

module chebyshev_gamma_log_eval import cgl_pkg::*; #(
    parameter int NUM_TERMS = NUM_TERMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cgl_in_if.sink    i_arg,
    cgl_out_if.source o_res
);

    // Term count held to the supported range
    localparam int N_EFF = (NUM_TERMS < 2) ? 2 :
                           ((NUM_TERMS > MAX_TERMS) ? MAX_TERMS : NUM_TERMS);
    localparam int NSTEP = N_EFF - 1;        // recurrence steps including the final one
    localparam int NST   = 2 * NSTEP + 1;    // register stages
    localparam int QW    = TERM_W - FRAC_W + 1;
    localparam logic [QW-1:0] POS_MAX = QW'((1 << (RES_W - 1)) - 1);
    localparam logic [QW-1:0] NEG_MAX = QW'(1 << (RES_W - 1));

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    t_term          w_term [NSTEP+1];

    // Stage enables ripple back from the output register
    assign w_en[NST-1] = !r_vld[NST-1] || o_res.ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign i_arg.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_arg.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Recurrence seed: a = c[n-2], b = c[n-1]
    always_comb begin
        w_term[0].x   = i_arg.x_value;
        w_term[0].oor = i_arg.x_value[X_W-1];
        w_term[0].a   = COEF_TAB[N_EFF-2];
        w_term[0].b   = COEF_TAB[N_EFF-1];
    end

    // Step s runs j = n-2-s and subtracts b from c[j-1]; the last step is a + x*b
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam bit FIN = (s == NSTEP - 1);
        localparam int CI  = FIN ? 0 : (N_EFF - 3 - s);
        t_step_en step_en;

        assign step_en.mul = w_en[2*s];
        assign step_en.add = w_en[2*s+1];

        cgl_step #(
            .COEF  (COEF_TAB[CI]),
            .FINAL (FIN)
        ) u_step (
            .i_clk  (i_clk),
            .i_en   (step_en),
            .i_term (w_term[s]),
            .o_term (w_term[s+1])
        );
    end

    // Round Q.48 to Q.24, half away from zero, then saturate to Q2.24; out-of-range gives zero
    logic                     s_neg;
    logic [TERM_W-1:0]        s_mag;
    logic [TERM_W:0]          s_rnd;
    logic [QW-1:0]            q;
    logic signed [RES_W-1:0]  n_func;
    logic signed [RES_W-1:0]  r_func;
    logic                     r_oor;

    always_comb begin
        s_neg = w_term[NSTEP].b[TERM_W-1];
        s_mag = s_neg ? TERM_W'(-w_term[NSTEP].b) : TERM_W'(w_term[NSTEP].b);
        s_rnd = (TERM_W+1)'(s_mag) + (TERM_W+1)'(1 << (FRAC_W - 1));
        q     = s_rnd[TERM_W:FRAC_W];
        if (w_term[NSTEP].oor) begin
            n_func = '0;
        end else if (s_neg) begin
            n_func = (q > NEG_MAX) ? -$signed(RES_W'(NEG_MAX)) : -$signed(q[RES_W-1:0]);
        end else begin
            n_func = (q > POS_MAX) ? $signed(POS_MAX[RES_W-1:0]) : $signed(q[RES_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            r_func <= n_func;
            r_oor  <= w_term[NSTEP].oor;
        end
    end

    assign o_res.valid        = r_vld[NST-1];
    assign o_res.func_value   = r_func;
    assign o_res.out_of_range = r_oor;

    // Checks
    `CGL_ASSERT(a_oor_zero, i_clk, i_rst_n,
        o_res.valid && o_res.out_of_range |-> o_res.func_value == '0,
        "out-of-range result not zero")
    `CGL_ASSERT(a_backpressure, i_clk, i_rst_n,
        !i_arg.ready |-> o_res.valid && !o_res.ready,
        "input stalled without output stall")
    `CGL_ASSERT(a_full_stall, i_clk, i_rst_n,
        !i_arg.ready |-> r_vld == '1,
        "input stalled with a bubble in the pipeline")
    `CGL_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_res.valid,
        "output valid after reset")

endmodule

### rtl/cgl_step.sv
`timescale 1ns / 1ps

// One recurrence step over two register stages:
//   stage 1: |b| * y as two partial products, t = coef - b
//   stage 2: b' = a + sign(b) * (sum of partials), a' = t
// FINAL uses y = x, otherwise y = 2x.
module cgl_step import cgl_pkg::*; #(
    parameter logic signed [TERM_W-1:0] COEF  = '0,
    parameter bit                       FINAL = 1'b0
) (
    input  logic     i_clk,
    input  t_step_en i_en,
    input  t_term    i_term,
    output t_term    o_term
);

    logic              neg;
    logic [TERM_W-1:0] mag;
    logic [MH_W-1:0]   mh;
    logic [FRAC_W-1:0] ml;
    logic [X_W-1:0]    y;
    logic [PH_W-1:0]   ph;
    logic [PL_W-1:0]   pl_full;

    logic [X_W-1:0]           r_x;
    logic                     r_oor;
    logic signed [TERM_W-1:0] r_a;
    logic signed [TERM_W-1:0] r_t;
    logic                     r_neg;
    logic [PH_W-1:0]          r_ph;
    logic [X_W-1:0]           r_pl;

    logic [PH_W-1:0]          sum;
    logic signed [TERM_W-1:0] prod;
    t_term                    n_term;
    t_term                    r_term;

    // sign-magnitude product truncates toward zero
    always_comb begin
        neg     = i_term.b[TERM_W-1];
        mag     = neg ? TERM_W'(-i_term.b) : TERM_W'(i_term.b);
        mh      = mag[TERM_W-1:FRAC_W];
        ml      = mag[FRAC_W-1:0];
        y       = FINAL ? {1'b0, i_term.x[FRAC_W-1:0]} : {i_term.x[FRAC_W-1:0], 1'b0};
        ph      = PH_W'(mh) * PH_W'(y);
        pl_full = PL_W'(ml) * PL_W'(y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_x   <= i_term.x;
            r_oor <= i_term.oor;
            r_a   <= i_term.a;
            r_t   <= COEF - i_term.b;
            r_neg <= neg;
            r_ph  <= ph;
            r_pl  <= pl_full[PL_W-1:FRAC_W];
        end
    end

    // terms stay well inside TERM_W for any in-range x, so no clamping is needed
    always_comb begin
        sum      = r_ph + PH_W'(r_pl);
        prod     = r_neg ? -$signed(sum[TERM_W-1:0]) : $signed(sum[TERM_W-1:0]);
        n_term.x   = r_x;
        n_term.oor = r_oor;
        n_term.a   = r_t;
        n_term.b   = r_a + prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.add) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cgl_pkg::*;

    // Terms of the series as built into the instance below
    localparam int SERIES_TERMS = NUM_TERMS_DEF;
    // Pipeline depth: two stages per multiply-add plus the rounding stage
    localparam int PIPE_LAT     = 2 * (SERIES_TERMS - 1) + 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int N_DIRECTED   = 20;

    // Q15.48 series coefficients; the tail ones are below the resolution
    localparam longint SER_COEF [MAX_TERMS] = '{
        64'sd64335796780601,
        64'sd62414379084075,
        -64'sd1869401394326,
        64'sd50817045501,
        -64'sd1175542676,
        64'sd23305738,
        -64'sd402082,
        64'sd6125,
        -64'sd83,
        64'sd1,
        64'sd0,
        64'sd0,
        64'sd0
    };
    localparam longint SER_LIM = 64'sd4611686018427387904;   // 2^62

    typedef struct packed {
        logic signed [RES_W-1:0] func_value;
        logic                    out_of_range;
    } t_series_res;

    // One row of directed stimulus; known rows carry a typed-in result
    typedef struct packed {
        logic [X_W-1:0]          x;
        logic                    known;
        logic signed [RES_W-1:0] func_value;
        logic                    out_of_range;
    } t_arg_row;

    localparam t_arg_row DIRECTED [N_DIRECTED] = '{
        '{25'h0000000, 1'b0, 26'sd0, 1'b0},   // zero
        '{25'h0000001, 1'b0, 26'sd0, 1'b0},   // smallest step
        '{25'h0000002, 1'b0, 26'sd0, 1'b0},
        '{25'h0000003, 1'b0, 26'sd0, 1'b0},
        '{25'h0000100, 1'b0, 26'sd0, 1'b0},
        '{25'h0400000, 1'b0, 26'sd0, 1'b0},   // 0.25
        '{25'h0800000, 1'b0, 26'sd0, 1'b0},   // 0.5
        '{25'h0C00000, 1'b0, 26'sd0, 1'b0},   // 0.75
        '{25'h07FFFFF, 1'b0, 26'sd0, 1'b0},
        '{25'h0AAAAAA, 1'b0, 26'sd0, 1'b0},
        '{25'h0555555, 1'b0, 26'sd0, 1'b0},
        '{25'h0123456, 1'b0, 26'sd0, 1'b0},
        '{25'h0FFFFFE, 1'b0, 26'sd0, 1'b0},
        '{25'h0FFFFFF, 1'b0, 26'sd0, 1'b0},   // just below one
        // argument at or above one: zero result, flag raised
        '{25'h1000000, 1'b1, 26'sd0, 1'b1},
        '{25'h1000001, 1'b1, 26'sd0, 1'b1},
        '{25'h1555555, 1'b1, 26'sd0, 1'b1},
        '{25'h1AAAAAA, 1'b1, 26'sd0, 1'b1},
        '{25'h1800000, 1'b1, 26'sd0, 1'b1},
        '{25'h1FFFFFF, 1'b1, 26'sd0, 1'b1}    // largest argument
    };

    logic i_clk;
    logic i_rst_n;

    cgl_in_if  arg_if ();
    cgl_out_if res_if ();

    chebyshev_gamma_log_eval #(
        .NUM_TERMS (SERIES_TERMS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_arg   (arg_if),
        .o_res   (res_if)
    );

    // Expected results, oldest first, pushed as each argument transaction lands
    t_series_res series_q [$];

    int fail_cnt    = 0;
    int sent_cnt    = 0;
    int checked_cnt = 0;
    int oor_cnt     = 0;
    int cycle_cnt   = 0;
    int idle_pct    = 0;   // sender gap probability, percent per cycle
    int stall_pct   = 0;   // receiver stall probability, percent per cycle
    bit hold_req    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Saturate to +/-2^62 as every sum of the recurrence does
    function automatic longint sat62(input longint v);
        if (v > SER_LIM) return SER_LIM;
        if (v < -SER_LIM) return -SER_LIM;
        return v;
    endfunction

    // sign(v) * floor(|v| * y / 2^24), magnitude capped at 2^62
    function automatic longint scale_q24(input longint v, input logic [63:0] y);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        neg = (v < 0);
        mag = neg ? 64'(-v) : 64'(v);
        hi  = mag >> FRAC_W;
        lo  = mag & 64'hFF_FFFF;
        r   = hi * y + ((lo * y) >> FRAC_W);
        if (r > 64'(SER_LIM)) r = 64'(SER_LIM);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Clenshaw-style recurrence on x itself, rounded to Q2.24
    function automatic t_series_res eval_series(input logic [X_W-1:0] x);
        t_series_res res;
        int          n;
        longint      a;
        longint      b;
        longint      t;
        longint      s;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        res = '0;
        if (x >= (X_W'(1) << FRAC_W)) begin
            res.out_of_range = 1'b1;
            return res;
        end
        n = SERIES_TERMS;
        if (n < 2) n = 2;
        if (n > MAX_TERMS) n = MAX_TERMS;
        a = SER_COEF[n-2];
        b = SER_COEF[n-1];
        for (int j = n - 2; j > 0; j--) begin
            t = sat62(SER_COEF[j-1] - b);
            b = sat62(a + scale_q24(b, 64'(x) << 1));
            a = t;
        end
        s   = sat62(a + scale_q24(b, 64'(x)));
        neg = (s < 0);
        mag = neg ? 64'(-s) : 64'(s);
        q   = (mag + 64'h80_0000) >> FRAC_W;
        if (neg) begin
            if (q > (64'd1 << 25)) q = 64'd1 << 25;
            res.func_value = RES_W'(~q + 64'd1);
        end else begin
            if (q > ((64'd1 << 25) - 64'd1)) q = (64'd1 << 25) - 64'd1;
            res.func_value = RES_W'(q);
        end
        return res;
    endfunction

    // One argument transaction, with random gaps ahead of it; valid stays
    // high afterwards so back-to-back items need no extra edge.
    task automatic send_arg(input logic [X_W-1:0] x, input t_series_res want);
        while ($urandom_range(99) < idle_pct) begin
            arg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        arg_if.valid   <= 1'b1;
        arg_if.x_value <= x;
        @(posedge i_clk);
        while (arg_if.ready !== 1'b1) @(posedge i_clk);
        series_q.push_back(want);
        sent_cnt++;
        if (want.out_of_range) oor_cnt++;
    endtask

    // Random arguments: mostly inside [0,1), weighted to the ends of the
    // range, with a share of out-of-range ones
    task automatic run_random(input int count);
        logic [X_W-1:0] x;
        int             pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                x = X_W'($urandom_range(24'hFF_FFFF, 0));
            else if (pick < 58)
                x = X_W'($urandom_range(255, 0));
            else if (pick < 71)
                x = X_W'(24'hFF_FFFF - $urandom_range(255, 0));
            else if (pick < 85)
                x = {1'b0, 24'($urandom())};
            else
                x = X_W'($urandom());
            send_arg(x, eval_series(x));
        end
    endtask

    task automatic wait_drained();
        while (series_q.size() != 0) @(posedge i_clk);
    endtask

    // Result side: check each transaction, then choose ready for the next edge.
    // A hold request parks ready low for a long stretch counted here.
    initial begin
        t_series_res want;
        int          hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (series_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    fail_cnt++;
                end else begin
                    want = series_q.pop_front();
                    checked_cnt++;
                    if (res_if.func_value !== want.func_value) begin
                        $error("func_value: expected %0d, actual %0d",
                               $signed(want.func_value), $signed(res_if.func_value));
                        fail_cnt++;
                    end
                    if (res_if.out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0b, actual %0b",
                               want.out_of_range, res_if.out_of_range);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_series_res want;
        arg_if.valid   <= 1'b0;
        arg_if.x_value <= '0;
        i_rst_n        <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back
        idle_pct  = 0;
        stall_pct = 0;
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].known) begin
                want.func_value   = DIRECTED[r].func_value;
                want.out_of_range = DIRECTED[r].out_of_range;
            end else begin
                want = eval_series(DIRECTED[r].x);
            end
            send_arg(DIRECTED[r].x, want);
        end

        // Random, no idling on either side
        run_random(160);

        // Sender gaps
        idle_pct = 56;
        run_random(160);

        // Sender pauses until the pipeline has emptied
        arg_if.valid <= 1'b0;
        wait_drained();

        // Receiver holds off while the sender keeps offering: pipeline fills
        // and the input stalls
        idle_pct = 0;
        hold_req = 1'b1;
        run_random(60);

        // Receiver stalls
        stall_pct = 56;
        run_random(160);

        // Sender gaps and receiver stalls together
        idle_pct  = 35;
        stall_pct = 35;
        run_random(160);

        arg_if.valid <= 1'b0;
        stall_pct = 0;
        wait_drained();
        repeat (2 * PIPE_LAT) @(posedge i_clk);

        if (series_q.size() != 0) begin
            $error("%0d expected results never arrived", series_q.size());
            fail_cnt++;
        end

        $display("tb: %0d arguments sent (%0d at or above one), %0d results checked",
                 sent_cnt, oor_cnt, checked_cnt);
        $display("tb: idle, gapped, stalled and held-off traffic, %0d cycles, %0d errors",
                 cycle_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
